>>> src/mpl_pkg.sv
// mpl_pkg: shared types, turn codes and angle helpers for the maze path learner
// no dependencies; imported by mpl_decide, mpl_ctrl and the top level
package mpl_pkg;

    typedef enum logic [1:0] {
        TURN_L = 2'd0,
        TURN_S = 2'd1,
        TURN_R = 2'd2,
        TURN_B = 2'd3
    } turn_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PUSH,
        S_FETCH,
        S_REDUCE
    } state_t;

    localparam logic       MODE_REPORT = 1'b0;
    localparam logic       MODE_READ   = 1'b1;

    localparam int         LEVEL_W = 10;
    localparam int         CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH   = 2'd2;

    localparam logic [LEVEL_W-1:0] EXIT_RESET     = 10'd100;
    localparam logic [LEVEL_W-1:0] STRAIGHT_RESET = 10'd200;
    localparam logic [LEVEL_W-1:0] FINISH_RESET   = 10'd600;

    typedef struct packed {
        logic  finished;
        turn_t turn;
    } decision_t;

    // angle in quarter turns (degrees in brackets): left 3 (270), straight 0, right 1 (90), back 2 (180)
    function automatic logic [1:0] quarter_of(input turn_t code);
        logic [1:0] q;
        case (code)
            TURN_L:  q = 2'd3;
            TURN_S:  q = 2'd0;
            TURN_R:  q = 2'd1;
            TURN_B:  q = 2'd2;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

    function automatic turn_t code_of(input logic [1:0] q);
        turn_t code;
        case (q)
            2'd0:    code = TURN_S;
            2'd1:    code = TURN_R;
            2'd2:    code = TURN_B;
            2'd3:    code = TURN_L;
            default: code = TURN_S;
        endcase
        return code;
    endfunction

endpackage

>>> src/mpl_ram.sv
// mpl_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
module mpl_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mpl_decide.sv
// mpl_decide: exit detection, finish pattern and left-hand turn choice
// depends on mpl_pkg
module mpl_decide
    import mpl_pkg::*;
(
    input  logic [LEVEL_W-1:0] left_level,
    input  logic [LEVEL_W-1:0] right_level,
    input  logic [LEVEL_W-1:0] centre_left_level,
    input  logic [LEVEL_W-1:0] centre_level,
    input  logic [LEVEL_W-1:0] centre_right_level,
    input  logic [LEVEL_W-1:0] exit_thr,
    input  logic [LEVEL_W-1:0] straight_thr,
    input  logic [LEVEL_W-1:0] finish_thr,
    output decision_t          dec
);

    logic has_left;
    logic has_right;
    logic has_straight;

    assign has_left     = left_level > exit_thr;
    assign has_right    = right_level > exit_thr;
    assign has_straight = (centre_left_level > straight_thr) ||
                          (centre_level > straight_thr) ||
                          (centre_right_level > straight_thr);

    always_comb
    begin
        dec.finished = (centre_left_level > finish_thr) &&
                       (centre_level > finish_thr) &&
                       (centre_right_level > finish_thr);
        if (has_left)
        begin
            dec.turn = TURN_L;
        end
        else if (has_straight)
        begin
            dec.turn = TURN_S;
        end
        else if (has_right)
        begin
            dec.turn = TURN_R;
        end
        else
        begin
            dec.turn = TURN_B;
        end
    end

endmodule

>>> src/mpl_ctrl.sv
// mpl_ctrl: sequencer for reads, push, top-of-stack fetch and path reduction
// depends on mpl_pkg; drives the turn store ram in the top level
module mpl_ctrl
    import mpl_pkg::*;
#(
    parameter int PATH_DEPTH = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          mode,
    input  logic [6:0]                    read_index,
    input  decision_t                     dec,
    output logic                          busy,
    output logic                          done,
    output logic [1:0]                    turn_code,
    output logic                          maze_finished,
    output logic [7:0]                    path_count,
    output logic                          path_full,
    output logic [1:0]                    entry_code,
    output logic                          ram_we,
    output logic [$clog2(PATH_DEPTH)-1:0] ram_waddr,
    output logic [1:0]                    ram_wdata,
    output logic [$clog2(PATH_DEPTH)-1:0] ram_raddr,
    input  logic [1:0]                    ram_rdata
);

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam int IW = (CW > 7) ? CW : 7;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           done_reg, done_next;
    turn_t          turn_out_reg, turn_out_next;
    logic           fin_reg, fin_next;
    logic           full_reg, full_next;
    logic [1:0]     entry_reg, entry_next;
    turn_t          turn_reg;
    turn_t          top_reg;
    logic           hit_reg;

    logic [IW-1:0]  idx_ext;
    logic [IW-1:0]  cnt_idx;
    logic           hit;
    logic [PW-1:0]  cnt_wide;
    logic [AW-1:0]  addr_top;
    logic [AW-1:0]  addr_second;
    logic [1:0]     quarter_sum;

    assign idx_ext     = IW'(read_index);
    assign cnt_idx     = IW'(count_reg);
    assign hit         = idx_ext < cnt_idx;
    assign cnt_wide    = PW'(count_reg);
    assign addr_top    = AW'(count_reg - CW'(1));
    assign addr_second = AW'(count_reg - CW'(2));
    // quarter angles add modulo four
    assign quarter_sum = quarter_of(turn_reg) + quarter_of(top_reg) +
                         quarter_of(turn_t'(ram_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            turn_out_reg <= TURN_L;
            fin_reg      <= 1'b0;
            full_reg     <= 1'b0;
            entry_reg    <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            turn_out_reg <= turn_out_next;
            fin_reg      <= fin_next;
            full_reg     <= full_next;
            entry_reg    <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            turn_reg <= dec.turn;
            hit_reg  <= hit;
        end
        if (state_reg == S_FETCH)
        begin
            top_reg <= turn_t'(ram_rdata);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        turn_out_next = turn_out_reg;
        fin_next      = fin_reg;
        full_next     = full_reg;
        entry_next    = entry_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        ram_wdata     = turn_reg;
        ram_raddr     = idx_ext[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (dec.finished)
                    begin
                        done_next     = 1'b1;
                        turn_out_next = TURN_L;
                        fin_next      = 1'b1;
                        full_next     = 1'b0;
                        entry_next    = 2'd0;
                    end
                    else if (count_reg == CW'(PATH_DEPTH))
                    begin
                        // request dropped, store and count untouched
                        done_next     = 1'b1;
                        turn_out_next = dec.turn;
                        fin_next      = 1'b0;
                        full_next     = 1'b1;
                        entry_next    = 2'd0;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_READ:
            begin
                done_next     = 1'b1;
                turn_out_next = TURN_L;
                fin_next      = 1'b0;
                full_next     = 1'b0;
                entry_next    = hit_reg ? ram_rdata : 2'd0;
                state_next    = S_IDLE;
            end
            S_PUSH:
            begin
                ram_we     = 1'b1;
                ram_raddr  = addr_top;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ram_raddr  = addr_second;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                // entry before last is the old top; three entries collapse to one
                if (count_reg >= CW'(2) && top_reg == TURN_B)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = addr_second;
                    ram_wdata  = code_of(quarter_sum);
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
                done_next     = 1'b1;
                turn_out_next = turn_reg;
                fin_next      = 1'b0;
                full_next     = 1'b0;
                entry_next    = 2'd0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign turn_code     = turn_out_reg;
    assign maze_finished = fin_reg;
    assign path_full     = full_reg;
    assign entry_code    = entry_reg;
    assign path_count    = cnt_wide[7:0];

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PATH_DEPTH))
        else $error("path count beyond depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer busy");

    a_finish_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && mode == MODE_REPORT && dec.finished)
        |=> done_reg && fin_reg && $stable(count_reg))
        else $error("finish item changed the path");

    a_reduce_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REDUCE |=> done_reg && !full_reg)
        else $error("push without result");

    a_finish_fields: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> turn_out_reg == TURN_L && !full_reg)
        else $error("finish result carries a turn");
`endif

endmodule

>>> src/maze_path_learner_top.sv
// maze_path_learner_top: learning phase of a left-hand wall follower with path reduction
// sequence: finish or full item answers from idle, read item passes the read state, pushed turn
// passes push, fetch and reduce; a push is a write, two stack reads, a conditional write-back
// busy drops in the cycle done strobes, so the next start is taken then; done cannot be held off
// reset: count and sequencer cleared, thresholds 100/200/600; turn store left uncleared
// depends on mpl_pkg, mpl_decide, mpl_ram, mpl_ctrl
module maze_path_learner_top
    import mpl_pkg::*;
#(
    parameter int PATH_DEPTH = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [LEVEL_W-1:0]   left_level,
    input  logic [LEVEL_W-1:0]   right_level,
    input  logic [LEVEL_W-1:0]   centre_left_level,
    input  logic [LEVEL_W-1:0]   centre_level,
    input  logic [LEVEL_W-1:0]   centre_right_level,
    input  logic [6:0]           read_index,
    output logic                 done,
    output logic [1:0]           turn_code,
    output logic                 maze_finished,
    output logic [7:0]           path_count,
    output logic                 path_full,
    output logic [1:0]           entry_code,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data
);

    localparam int AW = $clog2(PATH_DEPTH);

    logic [LEVEL_W-1:0] exit_thr_reg;
    logic [LEVEL_W-1:0] straight_thr_reg;
    logic [LEVEL_W-1:0] finish_thr_reg;
    decision_t          dec;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [1:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [1:0]         ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exit_thr_reg     <= EXIT_RESET;
            straight_thr_reg <= STRAIGHT_RESET;
            finish_thr_reg   <= FINISH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EXIT:     exit_thr_reg     <= cfg_data;
                CFG_STRAIGHT: straight_thr_reg <= cfg_data;
                CFG_FINISH:   finish_thr_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    mpl_decide u_decide (
        .left_level         (left_level),
        .right_level        (right_level),
        .centre_left_level  (centre_left_level),
        .centre_level       (centre_level),
        .centre_right_level (centre_right_level),
        .exit_thr           (exit_thr_reg),
        .straight_thr       (straight_thr_reg),
        .finish_thr         (finish_thr_reg),
        .dec                (dec)
    );

    mpl_ram #(
        .WIDTH (2),
        .DEPTH (PATH_DEPTH)
    ) u_turn_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mpl_ctrl #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .mode          (mode),
        .read_index    (read_index),
        .dec           (dec),
        .busy          (busy),
        .done          (done),
        .turn_code     (turn_code),
        .maze_finished (maze_finished),
        .path_count    (path_count),
        .path_full     (path_full),
        .entry_code    (entry_code),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

endmodule
